// ----- rtl/core/tiwe_pkg.sv -----
// Types and constants for the table interpolation block.
// No dependencies; imported by table_interp_with_extrapolation.
`timescale 1ns / 1ps
`default_nettype none

package tiwe_pkg;

  localparam int unsigned TableDepth  = 1024;
  localparam int unsigned IdxW        = 10;
  localparam int unsigned CntW        = 11;
  localparam int unsigned RadiusW     = 32;
  localparam int unsigned DensityW    = 48;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 32;

  // request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // result region codes
  localparam logic [1:0] REGION_BELOW  = 2'd0;
  localparam logic [1:0] REGION_INTERP = 2'd1;
  localparam logic [1:0] REGION_TAIL   = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_ENTRIES = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SCALE   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DECAY   = 2'd2;

  // Q1.62 one
  localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;

  typedef struct packed {
    logic                req_type;
    logic [IdxW-1:0]     entry_index;
    logic [RadiusW-1:0]  radius;
    logic [DensityW-1:0] density;
  } tiwe_req_t;

  typedef struct packed {
    logic [DensityW-1:0] potential;
    logic [1:0]          region;
    logic                fault;
  } tiwe_res_t;

endpackage

`default_nettype wire

// ----- rtl/core/table_interp_with_extrapolation.sv -----
// Piecewise-linear table lookup with exponential tail, scaled to a potential.
// Depends on tiwe_pkg.
`timescale 1ns / 1ps
`default_nettype none

// A load beat (req_type 0) writes one radius/density pair and gives no
// result; busy stays low. A query beat gives exactly one result, shown on
// result_o for one cycle with result_valid_o high; the receiver cannot
// stall it. busy is high while a query runs. Below the first radius a query
// reads the first and last entries and goes straight to the scale multiply.
// Inside the table, a binary search runs, each probe an address and a compare
// step (up to 11 probes for 1024 entries, one table read each), then the two
// interval ends are read, then one multiply of offset by density step (four
// 32x32 partial products), one bit-serial division and the final scale
// multiply. A zero-width interval skips the division and the first multiply.
// Above the table, the serial divider runs 21 times and the multiplier 29
// times; a decay exponent of 64 or more stops after the first division, a
// zero decay length or last radius after the first multiply. Most of a tail
// query is spent in the shared bit-serial divider. The table memory
// needs no clearing after reset: entries must be loaded before use.
// Configuration is taken at any time with cfg_ready_o high, and must only be
// written while the block is idle.
module table_interp_with_extrapolation (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     start,
  output logic                    busy,
  input  wire tiwe_pkg::tiwe_req_t req_i,
  input  wire                     cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire [1:0]               cfg_index_i,
  input  wire [31:0]              cfg_data_i,
  output logic                    result_valid_o,
  output tiwe_pkg::tiwe_res_t     result_o
);
  import tiwe_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_FIRST, S_LAST, S_SRCH_ADR, S_SRCH_CMP, S_RD_A, S_RD_B,
    S_IP_DIV, S_IP_END, S_EX_DIV, S_EX_INIT, S_EX_TDIV, S_EX_TACC,
    S_EX_SQ, S_EX_END, S_POT_END, S_MUL, S_DIV
  } state_e;

  // table memories
  logic [RadiusW-1:0]  r_mem [TableDepth];
  logic [DensityW-1:0] n_mem [TableDepth];
  logic [RadiusW-1:0]  r_rd_q;
  logic [DensityW-1:0] n_rd_q;
  logic [IdxW-1:0]     rd_addr;
  logic                we;

  // configuration
  logic [CntW-1:0] entries_q;
  logic [31:0]     scale_q;
  logic [15:0]     decay_q;

  // sequencer and datapath registers
  state_e state_q, state_d, ret_q, ret_d;
  logic [RadiusW-1:0]  r_q, r_d, r0_q, r0_d, r1_q, r1_d, rl_q, rl_d, w_q, w_d;
  logic [DensityW-1:0] n0_q, n0_d, n1_q, n1_d, nl_q, nl_d;
  logic [CntW-1:0]     n_q, n_d, lo_q, lo_d, hi_q, hi_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic                up_q, up_d;
  logic [63:0]         y_q, y_d, sum_q, sum_d;
  logic [4:0]          k_q, k_d;
  logic [2:0]          sq_q, sq_d;
  logic [1:0]          region_q, region_d;
  logic                fault_q, fault_d;
  // shared multiplier: 64x64 in four 32x32 partial products
  logic [63:0]         ma_q, ma_d, mb_q, mb_d, prod_q, prod_d;
  logic [1:0]          psh_q, psh_d;
  logic [2:0]          mcnt_q, mcnt_d;
  logic [127:0]        acc_q, acc_d;
  // shared restoring divider, one quotient bit a cycle
  logic [79:0]         dn_q, dn_d;
  logic [47:0]         rem_q, rem_d, dd_q, dd_d;
  logic [6:0]          dcnt_q, dcnt_d;
  // result
  logic                res_vld_q, res_vld_d;
  tiwe_res_t           res_q, res_d;

  assign busy           = (state_q != S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;
  assign we = (state_q == S_IDLE) && start && (req_i.req_type == REQ_LOAD);

  always_ff @(posedge clk_i) begin
    if (we) begin
      r_mem[req_i.entry_index] <= req_i.radius;
      n_mem[req_i.entry_index] <= req_i.density;
    end
    r_rd_q <= r_mem[rd_addr];
    n_rd_q <= n_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= 11'd2;
      scale_q   <= 32'd65536;
      decay_q   <= 16'd6554;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ENTRIES: entries_q <= cfg_data_i[CntW-1:0];
        CFG_SCALE:   scale_q   <= cfg_data_i;
        CFG_DECAY:   decay_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [11:0]         srch_sum;
    logic [IdxW-1:0]     mid;
    logic [RadiusW-1:0]  dr;
    logic [DensityW-1:0] diff;
    logic [31:0]         pa, pb;
    logic [127:0]        pext;
    logic [48:0]         rem_sh, rem_sub;
    logic [63:0]         t_new, s_new;
    logic [RadiusW-1:0]  w_new;

    state_d = state_q;  ret_d = ret_q;
    r_d = r_q;  r0_d = r0_q;  r1_d = r1_q;  rl_d = rl_q;  w_d = w_q;
    n0_d = n0_q;  n1_d = n1_q;  nl_d = nl_q;
    n_d = n_q;  lo_d = lo_q;  hi_d = hi_q;  idx_d = idx_q;  up_d = up_q;
    y_d = y_q;  sum_d = sum_q;
    k_d = k_q;  sq_d = sq_q;  region_d = region_q;  fault_d = fault_q;
    ma_d = ma_q;  mb_d = mb_q;  prod_d = prod_q;  psh_d = psh_q;
    mcnt_d = mcnt_q;  acc_d = acc_q;
    dn_d = dn_q;  rem_d = rem_q;  dd_d = dd_q;  dcnt_d = dcnt_q;
    res_vld_d = 1'b0;  res_d = res_q;
    rd_addr = '0;

    srch_sum = {1'b0, lo_q} + {1'b0, hi_q};
    mid      = srch_sum[IdxW:1];
    dr       = '0;
    diff     = '0;
    w_new    = r_rd_q - r1_q;
    t_new    = dn_q[63:0];
    s_new    = k_q[0] ? (sum_q - t_new) : (sum_q + t_new);
    pa       = mcnt_q[1] ? ma_q[63:32] : ma_q[31:0];
    pb       = mcnt_q[0] ? mb_q[63:32] : mb_q[31:0];
    case (psh_q)
      2'd0:    pext = {64'd0, prod_q};
      2'd1:    pext = {32'd0, prod_q, 32'd0};
      default: pext = {prod_q, 64'd0};
    endcase
    rem_sh  = {rem_q, dn_q[79]};
    rem_sub = rem_sh - {1'b0, dd_q};

    unique case (state_q)
      S_IDLE: begin
        if (start && (req_i.req_type == REQ_QUERY)) begin
          r_d     = req_i.radius;
          fault_d = 1'b0;
          if (entries_q < 11'd2)             n_d = 11'd2;
          else if (entries_q > 11'd1024)     n_d = 11'd1024;
          else                               n_d = entries_q;
          state_d = S_FIRST;
        end
      end
      S_FIRST: begin
        r0_d    = r_rd_q;
        n0_d    = n_rd_q;
        rd_addr = IdxW'(n_q - 11'd1);
        state_d = S_LAST;
      end
      S_LAST: begin
        rl_d = r_rd_q;
        nl_d = n_rd_q;
        if (r_q < r0_q) begin
          region_d = REGION_BELOW;
          ma_d = {16'd0, n0_q};  mb_d = {32'd0, scale_q};
          mcnt_d = '0;  acc_d = '0;  ret_d = S_POT_END;  state_d = S_MUL;
        end else if (r_q > r_rd_q) begin
          region_d = REGION_TAIL;
          ma_d = {48'd0, decay_q};  mb_d = {32'd0, r_rd_q};
          mcnt_d = '0;  acc_d = '0;  ret_d = S_EX_DIV;  state_d = S_MUL;
        end else begin
          region_d = REGION_INTERP;
          lo_d = '0;  hi_d = n_q;
          state_d = S_SRCH_ADR;
        end
      end
      S_SRCH_ADR: begin
        if (lo_q < hi_q) begin
          rd_addr = mid;
          state_d = S_SRCH_CMP;
        end else begin
          if (lo_q >= n_q)        idx_d = IdxW'(n_q - 11'd2);
          else if (lo_q == '0)    idx_d = '0;
          else                    idx_d = IdxW'(lo_q - 11'd1);
          rd_addr = idx_d;
          state_d = S_RD_A;
        end
      end
      S_SRCH_CMP: begin
        if (r_rd_q < r_q) lo_d = {1'b0, mid} + 11'd1;
        else              hi_d = {1'b0, mid};
        state_d = S_SRCH_ADR;
      end
      S_RD_A: begin
        r1_d    = r_rd_q;
        n1_d    = n_rd_q;
        rd_addr = idx_q + 10'd1;
        state_d = S_RD_B;
      end
      S_RD_B: begin
        // r_rd_q/n_rd_q hold the upper end of the interval
        if (r_rd_q <= r1_q) begin
          fault_d = 1'b1;
          ma_d = {16'd0, n1_q};  mb_d = {32'd0, scale_q};
          mcnt_d = '0;  acc_d = '0;  ret_d = S_POT_END;  state_d = S_MUL;
        end else begin
          w_d = w_new;
          dr  = (r_q <= r1_q) ? '0 : (r_q - r1_q);
          if (dr > w_new) dr = w_new;
          up_d = (n_rd_q >= n1_q);
          diff = (n_rd_q >= n1_q) ? (n_rd_q - n1_q) : (n1_q - n_rd_q);
          ma_d = {32'd0, dr};  mb_d = {16'd0, diff};
          mcnt_d = '0;  acc_d = '0;  ret_d = S_IP_DIV;  state_d = S_MUL;
        end
      end
      S_IP_DIV: begin
        dn_d = acc_q[79:0];  dd_d = {16'd0, w_q};  rem_d = '0;  dcnt_d = '0;
        ret_d = S_IP_END;  state_d = S_DIV;
      end
      S_IP_END: begin
        ma_d = up_q ? {16'd0, n1_q + dn_q[47:0]} : {16'd0, n1_q - dn_q[47:0]};
        mb_d = {32'd0, scale_q};
        mcnt_d = '0;  acc_d = '0;  ret_d = S_POT_END;  state_d = S_MUL;
      end
      S_EX_DIV: begin
        if (acc_q[47:0] == '0) begin
          ma_d = '0;  mb_d = {32'd0, scale_q};
          mcnt_d = '0;  acc_d = '0;  ret_d = S_POT_END;  state_d = S_MUL;
        end else begin
          dn_d = {16'd0, r_q - rl_q, 32'd0};
          dd_d = acc_q[47:0];  rem_d = '0;  dcnt_d = '0;
          ret_d = S_EX_INIT;  state_d = S_DIV;
        end
      end
      S_EX_INIT: begin
        if (dn_q[79:22] != '0) begin
          // decay exponent of 64 or more: density is zero
          ma_d = '0;  mb_d = {32'd0, scale_q};
          mcnt_d = '0;  acc_d = '0;  ret_d = S_POT_END;  state_d = S_MUL;
        end else begin
          y_d    = {2'd0, dn_q[21:0], 40'd0};
          sum_d  = ONE_Q62;
          k_d    = 5'd1;
          ma_d = ONE_Q62;  mb_d = y_d;
          mcnt_d = '0;  acc_d = '0;  ret_d = S_EX_TDIV;  state_d = S_MUL;
        end
      end
      S_EX_TDIV: begin
        dn_d = {16'd0, acc_q[125:62]};  dd_d = {43'd0, k_q};
        rem_d = '0;  dcnt_d = '0;
        ret_d = S_EX_TACC;  state_d = S_DIV;
      end
      S_EX_TACC: begin
        sum_d  = s_new;
        if (k_q == 5'd20) begin
          sq_d = '0;
          ma_d = s_new;  mb_d = s_new;
        end else begin
          k_d  = k_q + 5'd1;
          ma_d = t_new;  mb_d = y_q;
        end
        mcnt_d = '0;  acc_d = '0;
        ret_d = (k_q == 5'd20) ? S_EX_SQ : S_EX_TDIV;
        state_d = S_MUL;
      end
      S_EX_SQ: begin
        sum_d = acc_q[125:62];
        if (sq_q == 3'd5) begin
          ma_d = {16'd0, nl_q};  mb_d = acc_q[125:62];  ret_d = S_EX_END;
        end else begin
          sq_d = sq_q + 3'd1;
          ma_d = acc_q[125:62];  mb_d = acc_q[125:62];  ret_d = S_EX_SQ;
        end
        mcnt_d = '0;  acc_d = '0;  state_d = S_MUL;
      end
      S_EX_END: begin
        ma_d = acc_q[125:62];  mb_d = {32'd0, scale_q};
        mcnt_d = '0;  acc_d = '0;  ret_d = S_POT_END;  state_d = S_MUL;
      end
      S_POT_END: begin
        res_vld_d    = 1'b1;
        res_d.region = region_q;
        if (acc_q[127:64] != '0) begin
          res_d.potential = '1;
          res_d.fault     = 1'b1;
        end else begin
          res_d.potential = acc_q[63:16];
          res_d.fault     = fault_q;
        end
        state_d = S_IDLE;
      end
      S_MUL: begin
        if (mcnt_q < 3'd4) begin
          prod_d = {32'd0, pa} * {32'd0, pb};
          psh_d  = {1'b0, mcnt_q[1]} + {1'b0, mcnt_q[0]};
        end
        if (mcnt_q != '0) acc_d = acc_q + pext;
        mcnt_d = mcnt_q + 3'd1;
        if (mcnt_q == 3'd4) state_d = ret_q;
      end
      S_DIV: begin
        if (!rem_sub[48]) begin
          rem_d = rem_sub[47:0];
          dn_d  = {dn_q[78:0], 1'b1};
        end else begin
          rem_d = rem_sh[47:0];
          dn_d  = {dn_q[78:0], 1'b0};
        end
        dcnt_d = dcnt_q + 7'd1;
        if (dcnt_q == 7'd79) state_d = ret_q;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;  ret_q <= S_IDLE;
      r_q <= '0;  r0_q <= '0;  r1_q <= '0;  rl_q <= '0;  w_q <= '0;
      n0_q <= '0;  n1_q <= '0;  nl_q <= '0;
      n_q <= 11'd2;  lo_q <= '0;  hi_q <= '0;  idx_q <= '0;  up_q <= 1'b0;
      y_q <= '0;  sum_q <= '0;
      k_q <= '0;  sq_q <= '0;  region_q <= '0;  fault_q <= 1'b0;
      ma_q <= '0;  mb_q <= '0;  prod_q <= '0;  psh_q <= '0;
      mcnt_q <= '0;  acc_q <= '0;
      dn_q <= '0;  rem_q <= '0;  dd_q <= '0;  dcnt_q <= '0;
      res_vld_q <= 1'b0;  res_q <= '0;
    end else begin
      state_q <= state_d;  ret_q <= ret_d;
      r_q <= r_d;  r0_q <= r0_d;  r1_q <= r1_d;  rl_q <= rl_d;  w_q <= w_d;
      n0_q <= n0_d;  n1_q <= n1_d;  nl_q <= nl_d;
      n_q <= n_d;  lo_q <= lo_d;  hi_q <= hi_d;  idx_q <= idx_d;  up_q <= up_d;
      y_q <= y_d;  sum_q <= sum_d;
      k_q <= k_d;  sq_q <= sq_d;  region_q <= region_d;  fault_q <= fault_d;
      ma_q <= ma_d;  mb_q <= mb_d;  prod_q <= prod_d;  psh_q <= psh_d;
      mcnt_q <= mcnt_d;  acc_q <= acc_d;
      dn_q <= dn_d;  rem_q <= rem_d;  dd_q <= dd_d;  dcnt_q <= dcnt_d;
      res_vld_q <= res_vld_d;  res_q <= res_d;
    end
  end

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_search_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH_CMP) |-> (lo_q < hi_q) && (hi_q <= n_q))
    else $error("search window out of order");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (dd_q != '0))
    else $error("division by zero");

  a_mul_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> (mcnt_q <= 3'd4))
    else $error("multiplier step count overrun");

endmodule

`default_nettype wire
